FILE: design/ppeu_pkg.sv
// shared types, constants and helper functions for the se(2) pose update pipeline
package ppeu_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int DIV_STEPS     = 31;
  localparam int POS_W         = 32;
  localparam int ANG_W         = 31;
  localparam int TRIG_W        = 32;
  localparam int CXY_W         = 34;
  localparam int Z_W           = 32;
  localparam int REM_W         = 60;
  localparam int LIM_W         = 21;
  localparam int SQH_W         = 15;
  localparam int STEP_W        = 5;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic signed [Z_W-1:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [Z_W-1:0] TWO_PI_Q28  = 32'sd1686629713;
  localparam logic signed [Z_W-1:0] HALF_PI_Q28 = 32'sd421657428;

  localparam logic signed [CXY_W-1:0]  GAIN_INV = 34'sd652032874;
  localparam logic signed [CXY_W-1:0]  ONE_WIDE = 34'sd1073741824;
  localparam logic signed [TRIG_W-1:0] ONE_Q30  = 32'sd1073741824;

  // register index taken from paddr above the byte lanes
  localparam logic [ADDR_W-3:0] REG_LIMIT = 1'b0;
  localparam logic [LIM_W-1:0]  LIMIT_RST = 21'd1;

  typedef struct packed {
    logic signed [CXY_W-1:0] x;
    logic signed [CXY_W-1:0] y;
    logic signed [Z_W-1:0]   z;
  } rot_t;

  typedef struct packed {
    logic [REM_W-1:0]     rem_s;
    logic [REM_W-1:0]     rem_c;
    logic [DIV_STEPS-1:0] q_s;
    logic [DIV_STEPS-1:0] q_c;
  } dvs_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  px;
    logic signed [POS_W-1:0]  py;
    logic signed [POS_W-1:0]  dx;
    logic signed [POS_W-1:0]  dy;
    logic signed [ANG_W-1:0]  hd;
    logic                     dt_neg;
    logic [ANG_W-1:0]         dt_mag;
    logic                     use_ser;
    logic [SQH_W-1:0]         sq_hi;
    logic                     neg_d;
    logic                     neg_h;
    logic signed [TRIG_W-1:0] ser_s;
    logic signed [TRIG_W-1:0] cos_h;
    logic signed [TRIG_W-1:0] sin_h;
    logic                     sgn_s;
    logic                     sgn_c;
    logic                     ovf_s;
    logic                     ovf_c;
  } ctx_t;

  function automatic logic [27:0] atan_q28(input logic [STEP_W-1:0] i);
    logic [27:0] v;
    case (i)
      5'd0:  v = 28'd210828714;
      5'd1:  v = 28'd124459457;
      5'd2:  v = 28'd65760959;
      5'd3:  v = 28'd33381290;
      5'd4:  v = 28'd16755422;
      5'd5:  v = 28'd8385879;
      5'd6:  v = 28'd4193963;
      5'd7:  v = 28'd2097109;
      5'd8:  v = 28'd1048571;
      5'd9:  v = 28'd524287;
      5'd10: v = 28'd262144;
      5'd11: v = 28'd131072;
      5'd12: v = 28'd65536;
      5'd13: v = 28'd32768;
      5'd14: v = 28'd16384;
      5'd15: v = 28'd8192;
      5'd16: v = 28'd4096;
      5'd17: v = 28'd2048;
      5'd18: v = 28'd1024;
      5'd19: v = 28'd512;
      5'd20: v = 28'd256;
      5'd21: v = 28'd128;
      5'd22: v = 28'd64;
      5'd23: v = 28'd32;
      5'd24: v = 28'd16;
      5'd25: v = 28'd8;
      5'd26: v = 28'd4;
      5'd27: v = 28'd2;
      5'd28: v = 28'd1;
      default: v = 28'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [TRIG_W-1:0] clamp_q30(input logic signed [CXY_W-1:0] v);
    logic signed [TRIG_W-1:0] r;
    if (v > ONE_WIDE) begin
      r = ONE_Q30;
    end else if (v < -ONE_WIDE) begin
      r = -ONE_Q30;
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: design/ppeu_cordic_cell.sv
// one rotation-mode cordic micro-rotation for the twist angle and the heading lanes
module ppeu_cordic_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [ppeu_pkg::STEP_W-1:0]  step,
  input  logic                         vld_i,
  input  ppeu_pkg::rot_t               rd_i,
  input  ppeu_pkg::rot_t               rh_i,
  input  ppeu_pkg::ctx_t               ctx_i,
  output logic                         vld_o,
  output ppeu_pkg::rot_t               rd_o,
  output ppeu_pkg::rot_t               rh_o,
  output ppeu_pkg::ctx_t               ctx_o
);
  import ppeu_pkg::*;

  logic vld_r;
  rot_t rd_r, rd_nxt, rh_r, rh_nxt;
  ctx_t ctx_r;

  function automatic rot_t rot_step(input rot_t r, input logic [STEP_W-1:0] k);
    rot_t o;
    logic signed [CXY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]   at;
    xs = r.x >>> k;
    ys = r.y >>> k;
    at = $signed({4'b0, atan_q28(k)});
    if (!r.z[Z_W-1]) begin
      o.x = r.x - ys;
      o.y = r.y + xs;
      o.z = r.z - at;
    end else begin
      o.x = r.x + ys;
      o.y = r.y - xs;
      o.z = r.z + at;
    end
    return o;
  endfunction

  always_comb begin
    rd_nxt = rot_step(rd_i, step);
    rh_nxt = rot_step(rh_i, step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r  <= rd_nxt;
      rh_r  <= rh_nxt;
      ctx_r <= ctx_i;
    end
  end

  assign vld_o = vld_r;
  assign rd_o  = rd_r;
  assign rh_o  = rh_r;
  assign ctx_o = ctx_r;

endmodule

FILE: design/ppeu_div_cell.sv
// one restoring-division step producing a quotient bit for both s and c
module ppeu_div_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic [ppeu_pkg::STEP_W-1:0]  kshift,
  input  logic                         vld_i,
  input  ppeu_pkg::dvs_t               dv_i,
  input  ppeu_pkg::ctx_t               ctx_i,
  output logic                         vld_o,
  output ppeu_pkg::dvs_t               dv_o,
  output ppeu_pkg::ctx_t               ctx_o
);
  import ppeu_pkg::*;

  logic             vld_r;
  dvs_t             dv_r, dv_nxt;
  ctx_t             ctx_r;
  logic [REM_W:0]   dsh;
  logic             ge_s, ge_c;

  always_comb begin
    dsh  = {{(REM_W+1-ANG_W){1'b0}}, ctx_i.dt_mag} << kshift;
    ge_s = {1'b0, dv_i.rem_s} >= dsh;
    ge_c = {1'b0, dv_i.rem_c} >= dsh;
    dv_nxt.rem_s = ge_s ? dv_i.rem_s - dsh[REM_W-1:0] : dv_i.rem_s;
    dv_nxt.rem_c = ge_c ? dv_i.rem_c - dsh[REM_W-1:0] : dv_i.rem_c;
    dv_nxt.q_s   = {dv_i.q_s[DIV_STEPS-2:0], ge_s};
    dv_nxt.q_c   = {dv_i.q_c[DIV_STEPS-2:0], ge_c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r  <= dv_nxt;
      ctx_r <= ctx_i;
    end
  end

  assign vld_o = vld_r;
  assign dv_o  = dv_r;
  assign ctx_o = ctx_r;

endmodule

FILE: design/planar_pose_exponential_update.sv
// se(2) exponential-map pose update: pose plus twist in, advanced pose out.
// Fully pipelined, one transaction per cycle in steady state. From input to output: input
// register, angle prep, 24 cordic cells (twist angle and heading side by side), trig post
// stage, divider setup stage, 31 division cells (one quotient bit each for s and c), select
// stage, product, combine and rotation stages, and the output register. The pipeline stalls
// only when its last stage holds a result and the output register is still full.
// small_angle_limit sits at byte address 0; below that |dtheta| the series replaces division.
module planar_pose_exponential_update (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ppeu_pkg::POS_W-1:0]   in_pose_x,
  input  logic signed [ppeu_pkg::POS_W-1:0]   in_pose_y,
  input  logic signed [ppeu_pkg::ANG_W-1:0]   in_pose_heading,
  input  logic signed [ppeu_pkg::POS_W-1:0]   in_twist_dx,
  input  logic signed [ppeu_pkg::POS_W-1:0]   in_twist_dy,
  input  logic signed [ppeu_pkg::ANG_W-1:0]   in_twist_dtheta,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ppeu_pkg::POS_W-1:0]   out_new_x,
  output logic signed [ppeu_pkg::POS_W-1:0]   out_new_y,
  output logic signed [ppeu_pkg::ANG_W-1:0]   out_new_heading,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ppeu_pkg::ADDR_W-1:0]         paddr,
  input  logic [ppeu_pkg::DATA_W-1:0]         pwdata,
  output logic [ppeu_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import ppeu_pkg::*;

  // configuration
  logic [LIM_W-1:0] limit_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[ADDR_W-1:2] == REG_LIMIT) ?
                  {{(DATA_W-LIM_W){1'b0}}, limit_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_wr && paddr[ADDR_W-1:2] == REG_LIMIT) begin
      limit_r <= pwdata[LIM_W-1:0];
    end
  end

  // flow control
  logic adv, v7_r, out_valid_r;
  assign adv      = !v7_r || !out_valid_r || out_ready;
  assign in_ready = adv;

  // stage 0: input capture
  logic                    v0_r;
  logic signed [POS_W-1:0] px0_r, py0_r, dx0_r, dy0_r;
  logic signed [ANG_W-1:0] ph0_r, dt0_r;
  logic [LIM_W-1:0]        lim0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px0_r  <= in_pose_x;
      py0_r  <= in_pose_y;
      ph0_r  <= in_pose_heading;
      dx0_r  <= in_twist_dx;
      dy0_r  <= in_twist_dy;
      dt0_r  <= in_twist_dtheta;
      lim0_r <= limit_r;
    end
  end

  // stage 1: angle wrap and quadrant fold, heading sum, series square
  function automatic logic signed [Z_W-1:0] wrap_ang(input logic signed [Z_W-1:0] a);
    logic signed [Z_W-1:0] r;
    if (a > PI_Q28) begin
      r = a - TWO_PI_Q28;
    end else if (a <= -PI_Q28) begin
      r = a + TWO_PI_Q28;
    end else begin
      r = a;
    end
    return r;
  endfunction

  logic                    v1_r;
  rot_t                    rd1_r, rd1_nxt, rh1_r, rh1_nxt;
  ctx_t                    ctx1_r, ctx1_nxt;
  logic signed [Z_W-1:0]   zd, zh, hsum;
  logic [ANG_W-1:0]        mag1;
  logic [2*LIM_W-1:0]      sq1;

  always_comb begin
    zd   = wrap_ang(Z_W'(dt0_r));
    zh   = wrap_ang(Z_W'(ph0_r));
    hsum = wrap_ang(Z_W'(ph0_r) + Z_W'(dt0_r));
    mag1 = dt0_r[ANG_W-1] ? ANG_W'(-dt0_r) : ANG_W'(dt0_r);
    sq1  = mag1[LIM_W-1:0] * mag1[LIM_W-1:0];

    ctx1_nxt        = '0;
    ctx1_nxt.px     = px0_r;
    ctx1_nxt.py     = py0_r;
    ctx1_nxt.dx     = dx0_r;
    ctx1_nxt.dy     = dy0_r;
    ctx1_nxt.hd     = hsum[ANG_W-1:0];
    ctx1_nxt.dt_neg = dt0_r[ANG_W-1];
    ctx1_nxt.dt_mag = mag1;
    ctx1_nxt.use_ser = (mag1 == '0) || (mag1 < {{(ANG_W-LIM_W){1'b0}}, lim0_r});
    ctx1_nxt.sq_hi  = sq1[27 +: SQH_W];

    rd1_nxt.x = GAIN_INV;
    rd1_nxt.y = '0;
    rh1_nxt.x = GAIN_INV;
    rh1_nxt.y = '0;
    if (zd > HALF_PI_Q28) begin
      rd1_nxt.z = zd - PI_Q28;
      ctx1_nxt.neg_d = 1'b1;
    end else if (zd < -HALF_PI_Q28) begin
      rd1_nxt.z = zd + PI_Q28;
      ctx1_nxt.neg_d = 1'b1;
    end else begin
      rd1_nxt.z = zd;
    end
    if (zh > HALF_PI_Q28) begin
      rh1_nxt.z = zh - PI_Q28;
      ctx1_nxt.neg_h = 1'b1;
    end else if (zh < -HALF_PI_Q28) begin
      rh1_nxt.z = zh + PI_Q28;
      ctx1_nxt.neg_h = 1'b1;
    end else begin
      rh1_nxt.z = zh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd1_r  <= rd1_nxt;
      rh1_r  <= rh1_nxt;
      ctx1_r <= ctx1_nxt;
    end
  end

  // cordic chain
  logic vc  [0:CORDIC_STAGES];
  rot_t rdc [0:CORDIC_STAGES];
  rot_t rhc [0:CORDIC_STAGES];
  ctx_t cxc [0:CORDIC_STAGES];

  assign vc[0]  = v1_r;
  assign rdc[0] = rd1_r;
  assign rhc[0] = rh1_r;
  assign cxc[0] = ctx1_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    ppeu_cordic_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .step  (STEP_W'(i)),
      .vld_i (vc[i]),
      .rd_i  (rdc[i]),
      .rh_i  (rhc[i]),
      .ctx_i (cxc[i]),
      .vld_o (vc[i+1]),
      .rd_o  (rdc[i+1]),
      .rh_o  (rhc[i+1]),
      .ctx_o (cxc[i+1])
    );
  end

  // stage 2: sign restore, saturation, series sine term
  logic                     v2_r;
  logic signed [TRIG_W-1:0] cd2_r, sd2_r;
  ctx_t                     ctx2_r, ctx2_nxt;
  logic signed [TRIG_W-1:0] cd2_nxt, sd2_nxt;
  logic [SQH_W+16:0]        div3;
  rot_t                     rde, rhe;

  always_comb begin
    rde = rdc[CORDIC_STAGES];
    rhe = rhc[CORDIC_STAGES];
    ctx2_nxt = cxc[CORDIC_STAGES];
    cd2_nxt  = clamp_q30(ctx2_nxt.neg_d ? -rde.x : rde.x);
    sd2_nxt  = clamp_q30(ctx2_nxt.neg_d ? -rde.y : rde.y);
    ctx2_nxt.cos_h = clamp_q30(ctx2_nxt.neg_h ? -rhe.x : rhe.x);
    ctx2_nxt.sin_h = clamp_q30(ctx2_nxt.neg_h ? -rhe.y : rhe.y);
    // floor(v / 3) by reciprocal multiply, exact for the 15-bit range
    div3 = ctx2_nxt.sq_hi * 17'd43691;
    ctx2_nxt.ser_s = ONE_Q30 - $signed({16'b0, div3[SQH_W+16:17]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= vc[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cd2_r  <= cd2_nxt;
      sd2_r  <= sd2_nxt;
      ctx2_r <= ctx2_nxt;
    end
  end

  // stage 3: divider setup
  logic              v3_r;
  dvs_t              dv3_r, dv3_nxt;
  ctx_t              ctx3_r, ctx3_nxt;
  logic [ANG_W-1:0]  sd_abs;
  logic [TRIG_W:0]   omc;
  logic [REM_W+1:0]  den_top;

  always_comb begin
    ctx3_nxt = ctx2_r;
    sd_abs   = sd2_r[TRIG_W-1] ? ANG_W'(-sd2_r) : ANG_W'(sd2_r);
    omc      = {1'b0, ONE_Q30} - {cd2_r[TRIG_W-1], cd2_r};
    dv3_nxt.rem_s = {1'b0, sd_abs, 28'b0};
    dv3_nxt.rem_c = {omc[TRIG_W-1:0], 28'b0};
    dv3_nxt.q_s   = '0;
    dv3_nxt.q_c   = '0;
    den_top       = {ctx2_r.dt_mag, 31'b0};
    // quotient would need more than 31 bits: saturates anyway
    ctx3_nxt.ovf_s = {2'b0, dv3_nxt.rem_s} >= den_top;
    ctx3_nxt.ovf_c = {2'b0, dv3_nxt.rem_c} >= den_top;
    ctx3_nxt.sgn_s = sd2_r[TRIG_W-1] ^ ctx2_r.dt_neg;
    ctx3_nxt.sgn_c = ctx2_r.dt_neg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv3_r  <= dv3_nxt;
      ctx3_r <= ctx3_nxt;
    end
  end

  // division chain
  logic vd  [0:DIV_STEPS];
  dvs_t dvc [0:DIV_STEPS];
  ctx_t cxd [0:DIV_STEPS];

  assign vd[0]  = v3_r;
  assign dvc[0] = dv3_r;
  assign cxd[0] = ctx3_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    ppeu_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .kshift (STEP_W'(DIV_STEPS - 1 - i)),
      .vld_i  (vd[i]),
      .dv_i   (dvc[i]),
      .ctx_i  (cxd[i]),
      .vld_o  (vd[i+1]),
      .dv_o   (dvc[i+1]),
      .ctx_o  (cxd[i+1])
    );
  end

  // stage 4: saturate quotients, pick series or division
  logic                     v4_r;
  logic signed [TRIG_W-1:0] s4_r, c4_r, s4_nxt, c4_nxt;
  ctx_t                     ctx4_r, ctx4_nxt;
  logic [TRIG_W-1:0]        qs_mag, qc_mag, ser_c;
  dvs_t                     dve;

  always_comb begin
    dve      = dvc[DIV_STEPS];
    ctx4_nxt = cxd[DIV_STEPS];
    if (ctx4_nxt.ovf_s || {1'b0, dve.q_s} > ONE_Q30) begin
      qs_mag = ONE_Q30;
    end else begin
      qs_mag = {1'b0, dve.q_s};
    end
    if (ctx4_nxt.ovf_c || {1'b0, dve.q_c} > ONE_Q30) begin
      qc_mag = ONE_Q30;
    end else begin
      qc_mag = {1'b0, dve.q_c};
    end
    ser_c = {ctx4_nxt.dt_mag, 1'b0};
    if (ctx4_nxt.use_ser) begin
      s4_nxt = ctx4_nxt.ser_s;
      c4_nxt = ctx4_nxt.dt_neg ? -$signed(ser_c) : $signed(ser_c);
    end else begin
      s4_nxt = ctx4_nxt.sgn_s ? -$signed(qs_mag) : $signed(qs_mag);
      c4_nxt = ctx4_nxt.sgn_c ? -$signed(qc_mag) : $signed(qc_mag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= vd[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r   <= s4_nxt;
      c4_r   <= c4_nxt;
      ctx4_r <= ctx4_nxt;
    end
  end

  // stage 5: local translation products
  logic                    v5_r;
  logic signed [63:0]      p1_r, p2_r, p3_r, p4_r;
  ctx_t                    ctx5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r   <= 64'(ctx4_r.dx) * 64'(s4_r);
      p2_r   <= 64'(ctx4_r.dy) * 64'(c4_r);
      p3_r   <= 64'(ctx4_r.dx) * 64'(c4_r);
      p4_r   <= 64'(ctx4_r.dy) * 64'(s4_r);
      ctx5_r <= ctx4_r;
    end
  end

  // stage 6: combine and rescale to q16.16
  logic                    v6_r;
  logic signed [CXY_W-1:0] lx6_r, ly6_r;
  logic signed [63:0]      lxw, lyw;
  ctx_t                    ctx6_r;

  always_comb begin
    lxw = (p1_r - p2_r) >>> 30;
    lyw = (p3_r + p4_r) >>> 30;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lx6_r  <= lxw[CXY_W-1:0];
      ly6_r  <= lyw[CXY_W-1:0];
      ctx6_r <= ctx5_r;
    end
  end

  // stage 7: rotation by the pose heading
  logic signed [65:0] q1_r, q2_r, q3_r, q4_r;
  ctx_t               ctx7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_r   <= 66'(lx6_r) * 66'(ctx6_r.cos_h);
      q2_r   <= 66'(ly6_r) * 66'(ctx6_r.sin_h);
      q3_r   <= 66'(lx6_r) * 66'(ctx6_r.sin_h);
      q4_r   <= 66'(ly6_r) * 66'(ctx6_r.cos_h);
      ctx7_r <= ctx6_r;
    end
  end

  // output register, position sums wrap mod 2^32
  logic signed [POS_W-1:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic signed [ANG_W-1:0] oh_r;
  logic                    out_valid_nxt;
  logic                    load_out;

  assign load_out = adv & v7_r;

  always_comb begin
    ox_nxt = ctx7_r.px + q1_r[61:30] - q2_r[61:30];
    oy_nxt = ctx7_r.py + q3_r[61:30] + q4_r[61:30];
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oh_r <= ctx7_r.hd;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_x       = ox_r;
  assign out_new_y       = oy_r;
  assign out_new_heading = oh_r;

endmodule

FILE: design/ppeu_checker.sv
// port-level checks for the pose update block, bound to the top level
module ppeu_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [ppeu_pkg::POS_W-1:0]   in_pose_x,
  input logic signed [ppeu_pkg::POS_W-1:0]   in_pose_y,
  input logic signed [ppeu_pkg::ANG_W-1:0]   in_pose_heading,
  input logic signed [ppeu_pkg::POS_W-1:0]   in_twist_dx,
  input logic signed [ppeu_pkg::POS_W-1:0]   in_twist_dy,
  input logic signed [ppeu_pkg::ANG_W-1:0]   in_twist_dtheta,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [ppeu_pkg::POS_W-1:0]   out_new_x,
  input logic signed [ppeu_pkg::POS_W-1:0]   out_new_y,
  input logic signed [ppeu_pkg::ANG_W-1:0]   out_new_heading,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [ppeu_pkg::ADDR_W-1:0]         paddr,
  input logic [ppeu_pkg::DATA_W-1:0]         pwdata,
  input logic [ppeu_pkg::DATA_W-1:0]         prdata,
  input logic                                pready
);
  import ppeu_pkg::*;

  // heading always lands in (-pi, pi]
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(Z_W'(out_new_heading)) > -PI_Q28 &&
                   $signed(Z_W'(out_new_heading)) <= PI_Q28))
    else $error("heading out of range");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_new_x) && $stable(out_new_y))
    else $error("result dropped while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

  // limit register reads back what was written
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_LIMIT |=>
      prdata[LIM_W-1:0] == $past(pwdata[LIM_W-1:0]))
    else $error("limit register readback mismatch");

  a_cfg_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    prdata[DATA_W-1:LIM_W] == '0)
    else $error("unused register bits set");

endmodule

bind planar_pose_exponential_update ppeu_checker u_ppeu_checker (.*);

FILE: tb/ppeu_checker.sv
// checker for the pose update: predicts each accepted transaction and compares the results
module ppeu_tb_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [ppeu_pkg::POS_W-1:0] in_pose_x,
  input  logic signed [ppeu_pkg::POS_W-1:0] in_pose_y,
  input  logic signed [ppeu_pkg::ANG_W-1:0] in_pose_heading,
  input  logic signed [ppeu_pkg::POS_W-1:0] in_twist_dx,
  input  logic signed [ppeu_pkg::POS_W-1:0] in_twist_dy,
  input  logic signed [ppeu_pkg::ANG_W-1:0] in_twist_dtheta,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [ppeu_pkg::POS_W-1:0] out_new_x,
  input  logic signed [ppeu_pkg::POS_W-1:0] out_new_y,
  input  logic signed [ppeu_pkg::ANG_W-1:0] out_new_heading,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ppeu_pkg::ADDR_W-1:0]       paddr,
  input  logic [ppeu_pkg::DATA_W-1:0]       pwdata,
  output int                                errors,
  output int                                pending,
  output int                                n_results,
  output int                                n_series
);
  import ppeu_pkg::*;

  localparam longint PI_L     = 843314857;
  localparam longint TWO_PI_L = 1686629713;
  localparam longint HALF_PI_L = 421657428;
  localparam longint ONE_L    = 1073741824;
  localparam longint KINV_L   = 652032874;

  typedef struct packed {
    logic signed [POS_W-1:0] nx;
    logic signed [POS_W-1:0] ny;
    logic signed [ANG_W-1:0] nh;
  } pose_t;

  pose_t            pose_q[$];
  logic [LIM_W-1:0] angle_limit;

  function automatic longint angle_table(input int i);
    longint t[30] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                      4193963, 2097109, 1048571, 524287, 262144, 131072,
                      65536, 32768, 16384, 8192, 4096, 2048,
                      1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic longint sat_unit(input longint v);
    if (v > ONE_L) return ONE_L;
    if (v < -ONE_L) return -ONE_L;
    return v;
  endfunction

  function automatic longint wrap_pi(input longint a);
    longint r;
    r = a;
    while (r > PI_L) r -= TWO_PI_L;
    while (r <= -PI_L) r += TWO_PI_L;
    return r;
  endfunction

  task automatic sincos(input longint ang, output longint cs, output longint sn);
    longint z, x, y, xs, ys;
    bit     flip;
    z = wrap_pi(ang);
    x = KINV_L;
    y = 0;
    flip = 0;
    if (z > HALF_PI_L) begin
      z -= PI_L;
      flip = 1;
    end else if (z < -HALF_PI_L) begin
      z += PI_L;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= angle_table(i);
      end else begin
        x += ys; y -= xs; z += angle_table(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = sat_unit(x);
    sn = sat_unit(y);
  endtask

  task automatic advance_pose(output pose_t p, output bit series);
    longint px, py, ph, dx, dy, dt, mag, cd, sd, ch, sh, s, c, lx, ly, rx, ry;
    px = longint'(in_pose_x);
    py = longint'(in_pose_y);
    ph = longint'(in_pose_heading);
    dx = longint'(in_twist_dx);
    dy = longint'(in_twist_dy);
    dt = longint'(in_twist_dtheta);
    mag = dt < 0 ? -dt : dt;
    sincos(dt, cd, sd);
    sincos(ph, ch, sh);
    series = (dt == 0) || (mag < longint'(angle_limit));
    if (series) begin
      s = ONE_L - (dt * dt) / (longint'(6) << 26);
      c = dt * 2;
    end else begin
      s = (sd * 268435456) / dt;
      c = ((ONE_L - cd) * 268435456) / dt;
    end
    s = sat_unit(s);
    c = sat_unit(c);
    lx = (dx * s - dy * c) >>> 30;
    ly = (dx * c + dy * s) >>> 30;
    rx = ((lx * ch) >>> 30) - ((ly * sh) >>> 30);
    ry = ((lx * sh) >>> 30) + ((ly * ch) >>> 30);
    p.nx = POS_W'(px + rx);
    p.ny = POS_W'(py + ry);
    p.nh = ANG_W'(wrap_pi(ph + dt));
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  assign pending = pose_q.size();

  always @(posedge clk) begin
    pose_t p;
    bit    ser;
    if (!rst_n) begin
      angle_limit <= LIMIT_RST;
      errors      = 0;
      n_results   <= 0;
      n_series    <= 0;
    end else begin
      // register 0 only; other addresses are ignored
      if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_LIMIT)
        angle_limit <= pwdata[LIM_W-1:0];
      if (in_valid && in_ready) begin
        advance_pose(p, ser);
        pose_q.push_back(p);
        if (ser) n_series <= n_series + 1;
      end
      if (out_valid && out_ready) begin
        n_results <= n_results + 1;
        if (pose_q.size() == 0) begin
          report("unexpected transaction", 0, 0);
        end else begin
          p = pose_q.pop_front();
          if (out_new_x !== p.nx) report("new_x", out_new_x, p.nx);
          if (out_new_y !== p.ny) report("new_y", out_new_y, p.ny);
          if (out_new_heading !== p.nh) report("new_heading", out_new_heading, p.nh);
        end
      end
    end
  end
endmodule

FILE: tb/tb_top.sv
// top of the pose update testbench: clock, reset, stimulus, register writes and verdict
module tb_top;
  import ppeu_pkg::*;

  localparam int PI_I = 843314857;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [POS_W-1:0] in_pose_x = 0, in_pose_y = 0, in_twist_dx = 0, in_twist_dy = 0;
  logic signed [ANG_W-1:0] in_pose_heading = 0, in_twist_dtheta = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [POS_W-1:0] out_new_x, out_new_y;
  logic signed [ANG_W-1:0] out_new_heading;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = 0;
  logic [DATA_W-1:0] pwdata = 0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  int  errors, pending, n_results, n_series;
  int  idle_cycles = 0;
  int  burst_left = 0;
  int  n_sent = 0;
  bit  hold_req = 0;
  bit  no_stall = 0;

  always #6 clk = ~clk;

  planar_pose_exponential_update u_top (.*);

  ppeu_tb_checker u_chk (.*);

  // receiver: random stall pattern, a no-stall mode, and one long hold-off on request
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end
      if (no_stall) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 99) < 65);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic reg_write(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic drain;
    int n;
    while (pending != 0) @(posedge clk);
    for (n = 0; n < 80; n++) @(posedge clk);
  endtask

  // one transaction; the caller is at a rising edge; angles use their low 31 bits
  task automatic send(input logic [31:0] px, py, dx, dy, input int ph, dt);
    int g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 0;
        for (g = $urandom_range(1, 12); g > 0; g--) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    in_pose_x <= px; in_pose_y <= py; in_pose_heading <= ANG_W'(ph);
    in_twist_dx <= dx; in_twist_dy <= dy; in_twist_dtheta <= ANG_W'(dt);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  function automatic int rand_angle(input int lim);
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return int'($urandom);
    if (k < 4 && lim > 0) return int'($urandom_range(0, 2 * lim)) - lim;
    if (k == 4) return int'($urandom_range(0, 64)) - 32;
    return int'($urandom_range(0, 2 * PI_I - 1)) - PI_I + 1;
  endfunction

  function automatic logic [31:0] rand_pos;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($urandom_range(0, 1 << 22) - (1 << 21));
      2: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return 32'($urandom_range(0, 1 << 18) - (1 << 17));
    endcase
  endfunction

  task automatic random_run(input int count, input int lim);
    int i;
    for (i = 0; i < count; i++) begin
      if (i == count / 2 && lim == 0) hold_req = 1;
      send(rand_pos(), rand_pos(), rand_pos(), rand_pos(), rand_angle(lim), rand_angle(lim));
    end
    in_valid <= 0;
  endtask

  initial begin
    int lims[5];
    int p;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    no_stall = 1;
    // directed: zero twist, field extremes, pi boundaries, out-of-range angles
    send(0, 0, 0, 0, 0, 0);
    send(32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0, 0);
    send(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, PI_I, PI_I);
    send(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, -PI_I, -PI_I);
    send(0, 0, 32'h00010000, 32'h00010000, -PI_I + 1, -PI_I + 1);
    send(0, 0, 32'h00010000, 0, 32'h3fffffff, 32'h3fffffff);
    send(0, 0, 32'h00010000, 0, 32'h40000000, 32'h40000000);
    send(1, -1, 32'h00020000, 32'hfffe0000, 0, 1);
    send(0, 0, 32'h00020000, 32'h00010000, 0, -1);
    send(5, 6, 32'h00030000, 32'h00040000, 421657428, 421657429);
    send(5, 6, 32'h00030000, 32'h00040000, -421657428, -421657429);
    send(0, 0, 32'hffffffff, 32'h00000001, 32'h55555555, 32'h2aaaaaaa);
    send(0, 0, 32'h00100000, 32'h00100000, PI_I / 2, PI_I / 3);
    in_valid <= 0;
    drain();
    reg_write(0, 0);
    reg_write(3'd4, 32'h000fffff);  // unmapped address, must be ignored
    send(0, 0, 32'h00010000, 32'h00010000, 0, 0);
    send(0, 0, 32'h00010000, 32'h00010000, 0, 1);
    send(0, 0, 32'h00010000, 32'h00010000, 0, 3);
    send(7, 7, 32'h00050000, 32'hfffb0000, 100, -2);
    in_valid <= 0;
    drain();
    no_stall = 0;
    lims = '{1, 0, 1048576, 32'h1fffff, 0};
    lims[4] = $urandom_range(2, 1048575);
    for (p = 0; p < 5; p++) begin
      reg_write(0, lims[p]);
      @(posedge clk);
      random_run(p == 1 ? 600 : 300, lims[p] & 32'h1fffff);
      drain();
    end
    reg_write(0, 1);
    $display("sent %0d transactions, %0d results checked, %0d on the series path",
             n_sent, n_results, n_series);
    $display("angle limits 0, 1, max and random; stalls, bursts and one long output hold-off");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

FILE: sim.f
design/ppeu_pkg.sv
design/ppeu_cordic_cell.sv
design/ppeu_div_cell.sv
design/planar_pose_exponential_update.sv
design/ppeu_checker.sv
tb/ppeu_checker.sv
tb/tb_top.sv
